>>> rtl/core/lks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lks_pkg
// Types and constants shared by the lowest-k rule selector.
// ----------------------------------------------------------------------------
package lks_pkg;

  localparam int MAX_RULES    = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int ADDR_W       = $clog2(MAX_RULES);
  localparam int CNT_W        = $clog2(MAX_RULES + 1);
  localparam int IDX_W        = 5;
  localparam int DEG_W        = 16;
  localparam int ENTRY_W      = DEG_W + IDX_W;
  localparam int CFG_W        = 6;

  // A kept entry is {degree, index}, so one unsigned compare sorts by degree
  // first and index second.
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] rule_index;
    logic [DEG_W-1:0] degree;
    logic             loaded;
    logic             last_rule;
  } rule_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_index;
    logic [DEG_W-1:0] chosen_degree;
    logic             empty_res;
    logic             last_result;
  } result_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_FULL_CHK = 6'b000010,
    ST_SHIFT    = 6'b000100,
    ST_PLACE    = 6'b001000,
    ST_END      = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

endpackage

>>> rtl/core/lowest_k_rule_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_k_rule_selector
// Keeps the qualifying rules of a block in a sorted store and, on the last
// rule, emits the lowest-degree ones in ascending order.
// ----------------------------------------------------------------------------
// A rule is taken when start is high and busy is low. Rules that are loaded
// and have a nonzero degree are inserted into a sorted store by walking it
// from the tail, one entry per cycle through a single registered read port.
// A rule not kept, or meeting an empty store, skips the walk. After
// the last rule of a block, results are emitted one result per cycle on
// result with result_valid high for exactly one cycle; the receiver cannot
// stall, so results must be captured as they appear. A block with no
// qualifying rule produces one result flagged empty. The configuration write
// channel is always ready and should only be used while busy is low.
// ----------------------------------------------------------------------------
module lowest_k_rule_selector
  import lks_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rule_in_t         rule_in,
  output logic             result_valid,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t             state;
  state_t             state_next;
  entry_t             kept_mem [MAX_RULES];
  entry_t             rdata;
  entry_t             packed_rule;
  logic               last_r;
  logic [CNT_W-1:0]   kept_count;
  logic [CFG_W-1:0]   rules_to_activate;
  logic [ADDR_W-1:0]  wpos;
  logic [ADDR_W-1:0]  emit_k;
  logic [CNT_W-1:0]   emit_n;
  logic [CNT_W-1:0]   emit_n_next;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  entry_t             mem_wdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic               accept;
  logic               qualify;
  logic               emit_last;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign qualify   = rule_in.loaded && (rule_in.degree != '0);
  assign emit_last = ((CNT_W'(emit_k) + 1'b1) == emit_n);

  always_comb begin
    emit_n_next = kept_count;
    if (CNT_W'(rules_to_activate) < emit_n_next) begin
      emit_n_next = CNT_W'(rules_to_activate);
    end
    if (CNT_W'(RESULT_LIMIT) < emit_n_next) begin
      emit_n_next = CNT_W'(RESULT_LIMIT);
    end
  end

  // Sequencer: next state, memory port control.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = wpos;
    mem_wdata  = packed_rule;
    rd_addr    = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_END;
          if (qualify) begin
            if (kept_count == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = {rule_in.degree, rule_in.rule_index};
            end else if (kept_count == CNT_W'(MAX_RULES)) begin
              rd_addr    = ADDR_W'(MAX_RULES - 1);
              state_next = ST_FULL_CHK;
            end else begin
              rd_addr    = ADDR_W'(kept_count - 1'b1);
              state_next = ST_SHIFT;
            end
          end
        end
      end
      ST_FULL_CHK: begin
        // The tail entry decides whether the new rule survives at all.
        if (rdata <= packed_rule) begin
          state_next = ST_END;
        end else begin
          rd_addr    = ADDR_W'(MAX_RULES - 2);
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        mem_we = 1'b1;
        if (rdata > packed_rule) begin
          mem_wdata = rdata;
          if (wpos == ADDR_W'(1)) begin
            state_next = ST_PLACE;
          end else begin
            rd_addr = ADDR_W'(wpos - 2'd2);
          end
        end else begin
          state_next = ST_END;
        end
      end
      ST_PLACE: begin
        mem_we     = 1'b1;
        state_next = ST_END;
      end
      ST_END: begin
        state_next = ST_IDLE;
        if (last_r && (kept_count != '0) && (emit_n_next != '0)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rd_addr = ADDR_W'(emit_k + 1'b1);
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      kept_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= kept_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      kept_count        <= '0;
      rules_to_activate <= '0;
      result_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        rules_to_activate <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && qualify && (kept_count == '0)) begin
            kept_count <= CNT_W'(1);
          end
        end
        ST_SHIFT: begin
          if (!(rdata > packed_rule) && (kept_count != CNT_W'(MAX_RULES))) begin
            kept_count <= kept_count + 1'b1;
          end
        end
        ST_PLACE: begin
          if (kept_count != CNT_W'(MAX_RULES)) begin
            kept_count <= kept_count + 1'b1;
          end
        end
        ST_END: begin
          if (last_r) begin
            if (kept_count == '0) begin
              result_valid <= 1'b1;
            end else if (emit_n_next == '0) begin
              kept_count <= '0;
            end
          end
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          if (emit_last) begin
            kept_count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers; these need no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          packed_rule <= {rule_in.degree, rule_in.rule_index};
          last_r      <= rule_in.last_rule;
          wpos        <= (kept_count == CNT_W'(MAX_RULES)) ? ADDR_W'(MAX_RULES - 1)
                                                            : ADDR_W'(kept_count);
        end
      end
      ST_SHIFT: begin
        if (rdata > packed_rule) begin
          wpos <= wpos - 1'b1;
        end
      end
      ST_END: begin
        emit_k <= '0;
        emit_n <= emit_n_next;
        result <= '{chosen_index: '0, chosen_degree: '0, empty_res: 1'b1,
                    last_result: 1'b1};
      end
      ST_EMIT: begin
        emit_k <= emit_k + 1'b1;
        result <= '{chosen_index: rdata[IDX_W-1:0],
                    chosen_degree: rdata[ENTRY_W-1:IDX_W],
                    empty_res: 1'b0,
                    last_result: emit_last};
      end
      default: begin
      end
    endcase
  end

endmodule
